/* sv/crv_pkg.sv */
// Package for the canonical request validator.
// Beat types, header layout offsets, status codes and range limits.
// No dependencies.
package crv_pkg;

    localparam int HEADER_BYTES = 26;
    localparam int HDR_IDX_W    = $clog2(HEADER_BYTES);

    // header byte offsets
    localparam int OFF_SCHEMA   = 0;
    localparam int OFF_NETWORK  = 1;
    localparam int OFF_KIND     = 5;
    localparam int OFF_DEST     = 6;
    localparam int OFF_DELIVERY = 14;
    localparam int OFF_PRIORITY = 15;
    localparam int OFF_POLICY   = 16;
    localparam int OFF_STORAGE  = 17;
    localparam int OFF_TTL      = 18;
    localparam int OFF_HOP      = 22;
    localparam int OFF_PERSIST  = 23;
    localparam int OFF_PLEN     = 24;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_LENGTH   = 3'd1;
    localparam logic [2:0] ST_FRAMING  = 3'd2;
    localparam logic [2:0] ST_RANGE    = 3'd3;
    localparam logic [2:0] ST_RESERVED = 3'd4;

    localparam logic [7:0]  SCHEMA_ID    = 8'd1;
    localparam logic [7:0]  DELIVERY_MAX = 8'd2;
    localparam logic [7:0]  PRIORITY_MAX = 8'd3;
    localparam logic [7:0]  FLAG_MAX     = 8'd1;
    localparam logic [31:0] TTL_MAX      = 32'd30000;
    localparam logic [7:0]  HOP_MAX      = 8'd10;

    typedef logic [HEADER_BYTES-1:0][7:0] hdr_bus_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] network;
        logic        dst_type;
        logic [63:0] destination;
        logic [1:0]  delivery_class;
        logic [1:0]  priority_level;
        logic        storage_mode;
        logic [14:0] ttl_ms;
        logic [3:0]  hop_cap;
        logic        sleep_keep;
        logic [7:0]  body_bytes;
    } out_beat_t;

endpackage

/* sv/crv_check.sv */
// Header decode and validation for the canonical request validator.
// Pure logic: header bytes and total byte count in, result beat out.
// Depends on crv_pkg.
module crv_check #(
    parameter int MAX_MESSAGE_BYTES = 256,
    parameter int CNT_W             = 9
) (
    input  crv_pkg::hdr_bus_t  hdr,
    input  logic [CNT_W-1:0]   total,
    output crv_pkg::out_beat_t result
);

    localparam int CMP_W = (CNT_W > 16) ? CNT_W : 16;

    logic [7:0]  schema;
    logic [31:0] network;
    logic [7:0]  kind;
    logic [63:0] dest;
    logic [7:0]  delivery;
    logic [7:0]  prio;
    logic [7:0]  policy;
    logic [7:0]  storage;
    logic [31:0] ttl;
    logic [7:0]  hop;
    logic [7:0]  persist;
    logic [15:0] plen;
    logic        len_bad;
    logic        frame_bad;
    logic        range_bad;
    logic        rsvd_bad;
    logic [CMP_W-1:0] body_len;

    assign schema   = hdr[crv_pkg::OFF_SCHEMA];
    assign network  = {hdr[crv_pkg::OFF_NETWORK], hdr[crv_pkg::OFF_NETWORK+1],
                       hdr[crv_pkg::OFF_NETWORK+2], hdr[crv_pkg::OFF_NETWORK+3]};
    assign kind     = hdr[crv_pkg::OFF_KIND];
    assign dest     = {hdr[crv_pkg::OFF_DEST],   hdr[crv_pkg::OFF_DEST+1],
                       hdr[crv_pkg::OFF_DEST+2], hdr[crv_pkg::OFF_DEST+3],
                       hdr[crv_pkg::OFF_DEST+4], hdr[crv_pkg::OFF_DEST+5],
                       hdr[crv_pkg::OFF_DEST+6], hdr[crv_pkg::OFF_DEST+7]};
    assign delivery = hdr[crv_pkg::OFF_DELIVERY];
    assign prio     = hdr[crv_pkg::OFF_PRIORITY];
    assign policy   = hdr[crv_pkg::OFF_POLICY];
    assign storage  = hdr[crv_pkg::OFF_STORAGE];
    assign ttl      = {hdr[crv_pkg::OFF_TTL],   hdr[crv_pkg::OFF_TTL+1],
                       hdr[crv_pkg::OFF_TTL+2], hdr[crv_pkg::OFF_TTL+3]};
    assign hop      = hdr[crv_pkg::OFF_HOP];
    assign persist  = hdr[crv_pkg::OFF_PERSIST];
    assign plen     = {hdr[crv_pkg::OFF_PLEN], hdr[crv_pkg::OFF_PLEN+1]};

    assign body_len = CMP_W'(total) - CMP_W'(crv_pkg::HEADER_BYTES);

    assign len_bad   = (total < CNT_W'(crv_pkg::HEADER_BYTES))
                    || (total > CNT_W'(MAX_MESSAGE_BYTES));
    assign frame_bad = (schema != crv_pkg::SCHEMA_ID) || (CMP_W'(plen) != body_len);
    assign range_bad = (network == 32'd0)
                    || (kind > crv_pkg::FLAG_MAX)
                    || (delivery > crv_pkg::DELIVERY_MAX)
                    || (prio > crv_pkg::PRIORITY_MAX)
                    || (policy != 8'd0)
                    || (storage > crv_pkg::FLAG_MAX)
                    || (ttl == 32'd0) || (ttl > crv_pkg::TTL_MAX)
                    || (hop == 8'd0) || (hop > crv_pkg::HOP_MAX)
                    || (persist > crv_pkg::FLAG_MAX);
    assign rsvd_bad  = (kind == 8'd0) && ((dest == '0) || (dest == '1));

    always_comb begin
        result = '0;
        if (len_bad) begin
            result.status = crv_pkg::ST_LENGTH;
        end else if (frame_bad) begin
            result.status = crv_pkg::ST_FRAMING;
        end else if (range_bad) begin
            result.status = crv_pkg::ST_RANGE;
        end else if (rsvd_bad) begin
            result.status = crv_pkg::ST_RESERVED;
        end else begin
            result.status         = crv_pkg::ST_OK;
            result.network        = network;
            result.dst_type       = kind[0];
            result.destination    = dest;
            result.delivery_class = delivery[1:0];
            result.priority_level = prio[1:0];
            result.storage_mode   = storage[0];
            result.ttl_ms         = ttl[14:0];
            result.hop_cap        = hop[3:0];
            result.sleep_keep     = persist[0];
            result.body_bytes     = plen[7:0];
        end
    end

endmodule

/* sv/canonical_request_validator_top.sv */
// Top level of the canonical request validator: byte counter, header store,
// pending-frame stage and result register. Depends on crv_pkg and crv_check.
//
//   channel | dir | handshake          | payload
//   s_      | in  | s_valid / s_ready  | s_data  (crv_pkg::in_beat_t)
//   m_      | out | m_valid / m_ready  | m_data  (crv_pkg::out_beat_t)
//
// One input beat per cycle while s_ready is high; the result for a message is registered
// after its last beat is taken: header store/count with pending flag, then result reg.
// Reset (aresetn low, synchronous) clears the count and both valid flags.
// s_ready drops only while a finished frame waits behind a stalled m_ not ready.
module canonical_request_validator_top #(
    parameter int MAX_MESSAGE_BYTES = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  crv_pkg::in_beat_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output crv_pkg::out_beat_t  m_data
);

    localparam int CNT_W = $clog2(MAX_MESSAGE_BYTES + 2);
    localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_MESSAGE_BYTES + 1);

    logic [CNT_W-1:0]   cnt_reg,   cnt_next;
    logic [CNT_W-1:0]   total_reg, total_next;
    logic               pend_reg,  pend_next;
    logic               mv_reg,    mv_next;
    crv_pkg::out_beat_t out_reg;
    logic [7:0]         hdr_reg [crv_pkg::HEADER_BYTES];
    crv_pkg::hdr_bus_t  hdr_bus;
    crv_pkg::out_beat_t chk_result;
    logic [CNT_W-1:0]   cnt_inc;
    logic               s_fire;
    logic               out_free;
    logic               pend_move;

    assign out_free  = !mv_reg || m_ready;
    assign pend_move = pend_reg && out_free;
    assign s_ready   = !pend_reg || out_free;
    assign s_fire    = s_valid && s_ready;
    assign cnt_inc   = (cnt_reg < CNT_SAT) ? cnt_reg + CNT_W'(1) : cnt_reg;

    always_comb begin
        cnt_next   = cnt_reg;
        total_next = total_reg;
        pend_next  = pend_reg && !pend_move;
        mv_next    = mv_reg && !m_ready;
        if (pend_move) begin
            mv_next = 1'b1;
        end
        if (s_fire) begin
            if (s_data.last) begin
                cnt_next   = '0;
                total_next = cnt_inc;
                pend_next  = 1'b1;
            end else begin
                cnt_next = cnt_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            pend_reg <= 1'b0;
            mv_reg   <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            pend_reg <= pend_next;
            mv_reg   <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        total_reg <= total_next;
        if (s_fire && (cnt_reg < CNT_W'(crv_pkg::HEADER_BYTES))) begin
            hdr_reg[cnt_reg[crv_pkg::HDR_IDX_W-1:0]] <= s_data.data_byte;
        end
        if (pend_move) begin
            out_reg <= chk_result;
        end
    end

    always_comb begin
        for (int i = 0; i < crv_pkg::HEADER_BYTES; i++) begin
            hdr_bus[i] = hdr_reg[i];
        end
    end

    crv_check #(
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES),
        .CNT_W             (CNT_W)
    ) u_check (
        .hdr    (hdr_bus),
        .total  (total_reg),
        .result (chk_result)
    );

    assign m_valid = mv_reg;
    assign m_data  = out_reg;

    a_cnt_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_SAT)
        else $error("byte count above saturation");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_data.last |=> cnt_reg == '0 && pend_reg)
        else $error("last beat did not close the frame");

    a_pend_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg && mv_reg && !m_ready |-> !s_ready)
        else $error("input taken while pending frame is stalled");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != crv_pkg::ST_OK) |->
            m_data.network == '0 && m_data.destination == '0 && m_data.ttl_ms == '0
            && m_data.hop_cap == '0 && m_data.body_bytes == '0)
        else $error("fields not cleared on error status");

    a_ok_ranges: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == crv_pkg::ST_OK) |->
            m_data.ttl_ms != '0 && m_data.hop_cap != '0
            && m_data.hop_cap <= 4'd10 && m_data.network != '0)
        else $error("ok status with out-of-range field");

endmodule

/* tb/sv/crv_frame_checker.sv */
// Checker for canonical_request_validator_top: watches both channels, predicts each
// result from the accepted bytes and compares it field by field.
// Depends on crv_pkg.
module crv_frame_checker #(
    parameter int MAX_MESSAGE_BYTES = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  crv_pkg::in_beat_t  s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  crv_pkg::out_beat_t m_data,
    output int                 fail_count,
    output int                 pending,
    output int                 checked
);
    timeunit 1ns;
    timeprecision 1ps;

    int                 msg_len = 0;
    int                 err_total = 0;
    int                 seen_total = 0;
    logic [7:0]         hdr_mem [crv_pkg::HEADER_BYTES];
    crv_pkg::out_beat_t results_due [$];

    function automatic logic [63:0] header_word(input int off, input int n);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < n; i++) begin
            v = {v[55:0], hdr_mem[off + i]};
        end
        return v;
    endfunction

    function automatic crv_pkg::out_beat_t judge_request(input int total);
        crv_pkg::out_beat_t r;
        logic [7:0]  schema, kind, delivery, prio, policy, storage, hop, persist;
        logic [31:0] network, ttl;
        logic [63:0] dest;
        logic [15:0] plen;
        r = '0;
        if (total < crv_pkg::HEADER_BYTES || total > MAX_MESSAGE_BYTES) begin
            r.status = crv_pkg::ST_LENGTH;
            return r;
        end
        schema   = hdr_mem[crv_pkg::OFF_SCHEMA];
        network  = 32'(header_word(crv_pkg::OFF_NETWORK, 4));
        kind     = hdr_mem[crv_pkg::OFF_KIND];
        dest     = header_word(crv_pkg::OFF_DEST, 8);
        delivery = hdr_mem[crv_pkg::OFF_DELIVERY];
        prio     = hdr_mem[crv_pkg::OFF_PRIORITY];
        policy   = hdr_mem[crv_pkg::OFF_POLICY];
        storage  = hdr_mem[crv_pkg::OFF_STORAGE];
        ttl      = 32'(header_word(crv_pkg::OFF_TTL, 4));
        hop      = hdr_mem[crv_pkg::OFF_HOP];
        persist  = hdr_mem[crv_pkg::OFF_PERSIST];
        plen     = 16'(header_word(crv_pkg::OFF_PLEN, 2));
        if (schema != crv_pkg::SCHEMA_ID || plen != 16'(total - crv_pkg::HEADER_BYTES)) begin
            r.status = crv_pkg::ST_FRAMING;
        end else if (network == '0 || kind > crv_pkg::FLAG_MAX
                     || delivery > crv_pkg::DELIVERY_MAX
                     || prio > crv_pkg::PRIORITY_MAX || policy != '0
                     || storage > crv_pkg::FLAG_MAX
                     || ttl == '0 || ttl > crv_pkg::TTL_MAX
                     || hop == '0 || hop > crv_pkg::HOP_MAX
                     || persist > crv_pkg::FLAG_MAX) begin
            r.status = crv_pkg::ST_RANGE;
        end else if (kind == '0 && (dest == '0 || &dest)) begin
            r.status = crv_pkg::ST_RESERVED;
        end else begin
            r.status         = crv_pkg::ST_OK;
            r.network        = network;
            r.dst_type       = kind[0];
            r.destination    = dest;
            r.delivery_class = delivery[1:0];
            r.priority_level = prio[1:0];
            r.storage_mode   = storage[0];
            r.ttl_ms         = ttl[14:0];
            r.hop_cap        = hop[3:0];
            r.sleep_keep     = persist[0];
            r.body_bytes     = plen[7:0];
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            err_total++;
        end
    endtask

    always @(posedge aclk) begin
        crv_pkg::out_beat_t want;
        if (!aresetn) begin
            msg_len = 0;
            results_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    $error("result beat with no request pending, status %0d", m_data.status);
                    err_total++;
                end else begin
                    want = results_due.pop_front();
                    seen_total++;
                    check_field("status", 64'(want.status), 64'(m_data.status));
                    check_field("network", 64'(want.network), 64'(m_data.network));
                    check_field("dst_type", 64'(want.dst_type), 64'(m_data.dst_type));
                    check_field("destination", want.destination, m_data.destination);
                    check_field("delivery_class", 64'(want.delivery_class),
                                64'(m_data.delivery_class));
                    check_field("priority_level", 64'(want.priority_level),
                                64'(m_data.priority_level));
                    check_field("storage_mode", 64'(want.storage_mode),
                                64'(m_data.storage_mode));
                    check_field("ttl_ms", 64'(want.ttl_ms), 64'(m_data.ttl_ms));
                    check_field("hop_cap", 64'(want.hop_cap), 64'(m_data.hop_cap));
                    check_field("sleep_keep", 64'(want.sleep_keep),
                                64'(m_data.sleep_keep));
                    check_field("body_bytes", 64'(want.body_bytes),
                                64'(m_data.body_bytes));
                end
            end
            if (s_valid && s_ready) begin
                if (msg_len < crv_pkg::HEADER_BYTES) begin
                    hdr_mem[msg_len] = s_data.data_byte;
                end
                // counter stops one past the max: enough to flag an over-long frame
                if (msg_len <= MAX_MESSAGE_BYTES) begin
                    msg_len++;
                end
                if (s_data.last) begin
                    results_due.push_back(judge_request(msg_len));
                    msg_len = 0;
                end
            end
        end
        pending    <= results_due.size();
        fail_count <= err_total;
        checked    <= seen_total;
    end

endmodule

/* tb/sv/canonical_request_validator_top_test.sv */
// Testbench top for canonical_request_validator_top: drives request bytes with
// random idling on both channels and reports the verdict.
// Depends on crv_pkg, crv_frame_checker and the DUT.
module canonical_request_validator_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MSG_MAX     = 256;
    localparam int QUIET_LIMIT = 200;
    localparam int DRAIN       = 10;

    typedef enum int {
        FLT_NETWORK, FLT_KIND, FLT_DELIVERY, FLT_PRIORITY, FLT_POLICY,
        FLT_STORAGE, FLT_TTL, FLT_HOP, FLT_PERSIST
    } fault_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    crv_pkg::in_beat_t  s_data;
    logic               m_valid;
    logic               m_ready;
    crv_pkg::out_beat_t m_data;

    int fail_count, pending, checked;
    int quiet_cycles = 0;
    int bytes_sent = 0;
    int msgs_sent = 0;
    bit idle_on = 1'b1;

    logic [7:0]  f_schema, f_kind, f_delivery, f_priority, f_policy;
    logic [7:0]  f_storage, f_hop, f_persist;
    logic [31:0] f_network, f_ttl;
    logic [63:0] f_dest;
    logic [15:0] f_plen;

    canonical_request_validator_top #(
        .MAX_MESSAGE_BYTES(MSG_MAX)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    crv_frame_checker #(
        .MAX_MESSAGE_BYTES(MSG_MAX)
    ) u_frame_chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles", QUIET_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result-side backpressure
    initial begin
        int gap;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (aresetn && idle_on && $urandom_range(0, 4) == 0) begin
                gap = $urandom_range(1, 3);
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_beat(input logic [7:0] b, input logic lst);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 3);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{data_byte: b, last: lst};
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic send_request(input int total);
        logic [crv_pkg::HEADER_BYTES*8-1:0] hdr_bits;
        logic [7:0]                         b;
        hdr_bits = {f_schema, f_network, f_kind, f_dest, f_delivery, f_priority,
                    f_policy, f_storage, f_ttl, f_hop, f_persist, f_plen};
        for (int i = 0; i < total; i++) begin
            b = (i < crv_pkg::HEADER_BYTES)
                ? hdr_bits[crv_pkg::HEADER_BYTES*8-1 - 8*i -: 8] : 8'($urandom);
            send_beat(b, i == total - 1);
        end
        msgs_sent++;
    endtask

    function automatic void make_good(input int plen);
        f_schema   = crv_pkg::SCHEMA_ID;
        f_network  = $urandom;
        if (f_network == '0) f_network = 32'd1;
        f_kind     = 8'($urandom_range(0, 1));
        f_dest     = {$urandom, $urandom};
        if (f_kind == '0 && (f_dest == '0 || &f_dest)) f_dest = 64'd1;
        f_delivery = 8'($urandom_range(0, crv_pkg::DELIVERY_MAX));
        f_priority = 8'($urandom_range(0, crv_pkg::PRIORITY_MAX));
        f_policy   = '0;
        f_storage  = 8'($urandom_range(0, crv_pkg::FLAG_MAX));
        f_ttl      = $urandom_range(1, crv_pkg::TTL_MAX);
        f_hop      = 8'($urandom_range(1, crv_pkg::HOP_MAX));
        f_persist  = 8'($urandom_range(0, crv_pkg::FLAG_MAX));
        f_plen     = 16'(plen);
    endfunction

    function automatic void make_noise();
        f_schema   = 8'($urandom);
        f_network  = $urandom;
        f_kind     = 8'($urandom);
        f_dest     = {$urandom, $urandom};
        f_delivery = 8'($urandom);
        f_priority = 8'($urandom);
        f_policy   = 8'($urandom);
        f_storage  = 8'($urandom);
        f_ttl      = $urandom;
        f_hop      = 8'($urandom);
        f_persist  = 8'($urandom);
        f_plen     = 16'($urandom);
    endfunction

    function automatic void break_field(input fault_t flt);
        case (flt)
            FLT_NETWORK:  f_network  = '0;
            FLT_KIND:     f_kind     = 8'($urandom_range(crv_pkg::FLAG_MAX + 1, 255));
            FLT_DELIVERY: f_delivery = 8'($urandom_range(crv_pkg::DELIVERY_MAX + 1, 255));
            FLT_PRIORITY: f_priority = 8'($urandom_range(crv_pkg::PRIORITY_MAX + 1, 255));
            FLT_POLICY:   f_policy   = 8'($urandom_range(1, 255));
            FLT_STORAGE:  f_storage  = 8'($urandom_range(crv_pkg::FLAG_MAX + 1, 255));
            FLT_TTL: begin
                if ($urandom_range(0, 1)) f_ttl = '0;
                else f_ttl = $urandom_range(crv_pkg::TTL_MAX + 1, 32'hFFFF_FFFF);
            end
            FLT_HOP: begin
                if ($urandom_range(0, 1)) f_hop = '0;
                else f_hop = 8'($urandom_range(crv_pkg::HOP_MAX + 1, 255));
            end
            FLT_PERSIST:  f_persist  = 8'($urandom_range(crv_pkg::FLAG_MAX + 1, 255));
            default: ;
        endcase
    endfunction

    task automatic random_request();
        int     plen, total, pick;
        fault_t flt;
        plen  = ($urandom_range(0, 19) == 0)
                ? $urandom_range(0, MSG_MAX - crv_pkg::HEADER_BYTES)
                : $urandom_range(0, 12);
        total = crv_pkg::HEADER_BYTES + plen;
        pick  = $urandom_range(0, 99);
        make_good(plen);
        if (pick < 55) begin
        end else if (pick < 75) begin
            break_field(fault_t'($urandom_range(0, flt.num() - 1)));
        end else if (pick < 80) begin
            f_kind = '0;
            f_dest = $urandom_range(0, 1) ? '1 : '0;
        end else if (pick < 85) begin
            do f_schema = 8'($urandom); while (f_schema == crv_pkg::SCHEMA_ID);
        end else if (pick < 89) begin
            if ($urandom_range(0, 1)) f_plen = 16'(plen + 1);
            else do f_plen = 16'($urandom); while (f_plen == plen);
        end else if (pick < 92) begin
            make_noise();
        end else if (pick < 97) begin
            total = $urandom_range(1, crv_pkg::HEADER_BYTES - 1);
        end else begin
            total = $urandom_range(MSG_MAX + 1, MSG_MAX + 40);
        end
        send_request(total);
    endtask

    initial begin
        fault_t flt;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // smallest legal frame, low field limits
        make_good(0);
        f_network = 32'd1; f_kind = '0; f_dest = 64'd1; f_delivery = '0; f_priority = '0;
        f_storage = '0; f_ttl = 32'd1; f_hop = 8'd1; f_persist = '0;
        send_request(crv_pkg::HEADER_BYTES);
        // largest legal frame, high field limits
        make_good(MSG_MAX - crv_pkg::HEADER_BYTES);
        f_network = '1; f_kind = 8'd1; f_dest = '1; f_delivery = crv_pkg::DELIVERY_MAX;
        f_priority = crv_pkg::PRIORITY_MAX; f_storage = crv_pkg::FLAG_MAX;
        f_ttl = crv_pkg::TTL_MAX; f_hop = crv_pkg::HOP_MAX;
        f_persist = crv_pkg::FLAG_MAX;
        send_request(MSG_MAX);
        // reserved destinations, and the all-zeros value on a non-node kind
        make_good(0); f_kind = '0; f_dest = '0; send_request(crv_pkg::HEADER_BYTES);
        make_good(0); f_kind = '0; f_dest = '1; send_request(crv_pkg::HEADER_BYTES);
        make_good(0); f_kind = 8'd1; f_dest = '0; send_request(crv_pkg::HEADER_BYTES);
        // length bounds and counter saturation
        make_good(0); send_request(1);
        make_good(0); send_request(crv_pkg::HEADER_BYTES - 1);
        make_good(MSG_MAX + 1 - crv_pkg::HEADER_BYTES); send_request(MSG_MAX + 1);
        make_good(0); send_request(MSG_MAX + 2);
        // framing
        make_good(0); f_schema = '0; send_request(crv_pkg::HEADER_BYTES);
        make_good(0); f_schema = '1; send_request(crv_pkg::HEADER_BYTES);
        make_good(4); f_plen = 16'd5; send_request(crv_pkg::HEADER_BYTES + 4);
        make_good(0); f_plen = 16'h0100; send_request(crv_pkg::HEADER_BYTES);
        // one range fault each, then the exact boundaries
        flt = flt.first();
        do begin
            make_good(0); break_field(flt); send_request(crv_pkg::HEADER_BYTES);
            flt = flt.next();
        end while (flt != flt.first());
        make_good(0); f_ttl = '0; send_request(crv_pkg::HEADER_BYTES);
        make_good(0); f_ttl = crv_pkg::TTL_MAX + 1; send_request(crv_pkg::HEADER_BYTES);
        make_good(0); f_hop = '0; send_request(crv_pkg::HEADER_BYTES);
        make_good(0); f_hop = crv_pkg::HOP_MAX + 1; send_request(crv_pkg::HEADER_BYTES);

        while (bytes_sent < 1400) random_request();
        idle_on = 1'b0;
        repeat (4) random_request();

        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);

        $display("drove %0d bytes in %0d requests: length, framing, range, reserved and ok",
                 bytes_sent, msgs_sent);
        $display("%0d result beats compared field by field, %0d mismatches",
                 checked, fail_count);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
